>>> rtl/core/gcd_pkg.sv
// Shared types, constants and the arctangent step table for the great-circle
// distance unit. No dependencies; every other file in rtl/core imports it.
`default_nettype none

package gcd_pkg;

   // angle / coordinate word used by the CORDIC cells (Q30, signed)
   localparam int XW = 34;
   typedef logic signed [XW-1:0] fix_type;

   localparam fix_type PI_Q30      = 34'sd3373259426;
   localparam fix_type HALF_PI_Q30 = 34'sd1686629713;
   localparam fix_type ONE_Q30     = 34'sd1073741824;
   localparam fix_type INV_GAIN    = 34'sd652032874;

   // unsigned pi for the degree-to-radian product
   localparam logic [31:0] PI_MAG = 32'd3373259426;

   // constant division by 45, one byte per cell
   localparam int DW         = 40;
   localparam int DIGW       = 8;
   localparam int DIGITS     = DW / DIGW;
   localparam int REMW       = 6;
   localparam int DIV_SHIFT  = 20;
   localparam logic [14:0] DIV_RECIP = 15'd23302;
   localparam logic [13:0] DIVISOR   = 14'd45;

   // square root recurrence
   localparam int SQW        = 64;
   localparam int SQRT_STEPS = 32;

   // radius register
   localparam int RADW = 26;
   localparam logic [RADW-1:0] RADIUS_RESET = 26'd6378140;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
   } cordic_vec_type;

   typedef struct packed {
      logic [DW-1:0]   dividend;
      logic [DW-1:0]   quotient;
      logic [REMW-1:0] remainder;
   } div_state_type;

   typedef struct packed {
      logic [SQW-1:0] rad;
      logic [SQW-1:0] root;
   } sqrt_state_type;

   localparam logic [31:0] ATAN_HEAD [10] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149
   };

   // atan(2^-i) in Q30, truncated
   function automatic fix_type atan_step(input int i);
      logic [63:0] t;
      if (i < 10) begin
         t = {32'd0, ATAN_HEAD[i[3:0]]};
      end else if (i <= 30) begin
         t = (64'd1 << (30 - i)) - 64'd1;
      end else begin
         t = '0;
      end
      return fix_type'(t);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/gcd_div_cell.sv
// One registered cell of the divide-by-45 chain: retires one byte of the
// dividend per cycle. Depends on gcd_pkg.
`default_nettype none

module gcd_div_cell import gcd_pkg::*; (
   input  logic          clock,
   input  div_state_type stage_in,
   output div_state_type stage_out
);

   div_state_type   div_ff, div_in;
   logic [13:0]     part;
   logic [28:0]     prod;
   logic [DIGW-1:0] qd;
   logic [13:0]     rem_full;

   // partial remainder times 256 plus next byte, divided by 45 through the reciprocal
   always_comb begin
      part     = {stage_in.remainder, stage_in.dividend[DW-1 -: DIGW]};
      prod     = part * DIV_RECIP;
      qd       = prod[DIV_SHIFT +: DIGW];
      rem_full = part - ({6'd0, qd} * DIVISOR);
      div_in.dividend  = {stage_in.dividend[DW-DIGW-1:0], {DIGW{1'b0}}};
      div_in.quotient  = {stage_in.quotient[DW-DIGW-1:0], qd};
      div_in.remainder = rem_full[REMW-1:0];
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   assign stage_out = div_ff;

endmodule

`default_nettype wire

>>> rtl/core/gcd_cordic_cell.sv
// One registered CORDIC micro-rotation, rotation or vectoring mode, fixed
// shift index. Depends on gcd_pkg.
`default_nettype none

module gcd_cordic_cell import gcd_pkg::*; #(
   parameter int IDX       = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic           clock,
   input  cordic_vec_type vec_in,
   output cordic_vec_type vec_out
);

   cordic_vec_type vec_ff, vec_in_next;
   fix_type x_s, y_s, z_s, dx, dy, step;
   logic    pos;

   always_comb begin
      x_s  = vec_in.x;
      y_s  = vec_in.y;
      z_s  = vec_in.z;
      dx   = y_s >>> IDX;
      dy   = x_s >>> IDX;
      step = atan_step(IDX);
      // direction: vectoring drives y to zero, rotation drives z to zero
      pos  = VECTORING ? !y_s[XW-1] : !z_s[XW-1];
      if (VECTORING) begin
         vec_in_next.x = pos ? x_s + dx : x_s - dx;
         vec_in_next.y = pos ? y_s - dy : y_s + dy;
         vec_in_next.z = pos ? z_s + step : z_s - step;
      end else begin
         vec_in_next.x = pos ? x_s - dx : x_s + dx;
         vec_in_next.y = pos ? y_s + dy : y_s - dy;
         vec_in_next.z = pos ? z_s - step : z_s + step;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in_next;
   end

   assign vec_out = vec_ff;

endmodule

`default_nettype wire

>>> rtl/core/gcd_sqrt_cell.sv
// One registered step of the digit-by-digit integer square root (one result
// bit per cell). Depends on gcd_pkg.
`default_nettype none

module gcd_sqrt_cell import gcd_pkg::*; #(
   parameter int K = 0
) (
   input  logic           clock,
   input  sqrt_state_type st_in,
   output sqrt_state_type st_out
);

   localparam logic [SQW-1:0] BIT_W = 64'd1 << (62 - 2 * K);

   sqrt_state_type st_ff, st_in_next;
   logic [SQW-1:0] trial;

   always_comb begin
      trial = st_in.root + BIT_W;
      if (st_in.rad >= trial) begin
         st_in_next.rad  = st_in.rad - trial;
         st_in_next.root = (st_in.root >> 1) + BIT_W;
      end else begin
         st_in_next.rad  = st_in.rad;
         st_in_next.root = st_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in_next;
   end

   assign st_out = st_ff;

endmodule

`default_nettype wire

>>> rtl/core/great_circle_distance_unit.sv
// Haversine great-circle distance pipeline, top level.
// Uses gcd_pkg, gcd_div_cell, gcd_cordic_cell, gcd_sqrt_cell.
//
// Usage:
//   Input: an item is taken on every rising edge with start high and busy
//   low. busy is never raised, so one item may be issued every cycle.
//   Output: rsp_strobe is high for exactly one cycle with rsp_distance
//   (2^-4 m, saturating) and rsp_result_null. The receiver cannot stall;
//   results arrive in issue order.
//   Pipeline: a row of 5 divide-by-45 cells, CORDIC_ITERATIONS
//   rotation cells, 32 square root cells and CORDIC_ITERATIONS vectoring
//   cells, plus fixed arithmetic stages.
//   Throughput: one item per cycle.
//   Radius: written through csr_valid/csr_data (csr_ready always high);
//   write only while no item is in flight.
//   Reset: synchronous, clears the in-flight valid bits and loads the
//   default radius; items in flight are dropped.
`default_nettype none

module great_circle_distance_unit import gcd_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [27:0]     req_start_latitude,
   input  logic signed [28:0]     req_start_longitude,
   input  logic signed [27:0]     req_end_latitude,
   input  logic signed [28:0]     req_end_longitude,
   input  logic                   req_start_absent,
   input  logic                   req_end_absent,
   output logic                   rsp_strobe,
   output logic [31:0]            rsp_distance,
   output logic                   rsp_result_null,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADW-1:0]        csr_data
);

   localparam int N   = CORDIC_ITERATIONS;
   localparam int LAT = 49 + 2 * N;

   // item tracking
   logic [LAT-1:0]  vld_ff, nul_ff;
   logic            take;
   logic [RADW-1:0] radius_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= RADIUS_RESET;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], take};
         if (csr_valid && csr_ready) begin
            radius_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      nul_ff <= {nul_ff[LAT-2:0], req_start_absent | req_end_absent};
   end

   // stage 0: differences and raw latitudes, lanes dlat, dlon, lat1, lat2
   logic signed [29:0] raw_ff [4];
   logic signed [29:0] raw_in [4];

   always_comb begin
      raw_in[0] = {{2{req_end_latitude[27]}}, req_end_latitude}
                - {{2{req_start_latitude[27]}}, req_start_latitude};
      raw_in[1] = {req_end_longitude[28], req_end_longitude}
                - {req_start_longitude[28], req_start_longitude};
      raw_in[2] = {{2{req_start_latitude[27]}}, req_start_latitude};
      raw_in[3] = {{2{req_end_latitude[27]}}, req_end_latitude};
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
   end

   cordic_vec_type rot_end [4];
   logic           neg_end [4];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      // half angles divide by 360*2^20, full latitudes by 180*2^20
      localparam int SH = (l < 2) ? 23 : 22;
      localparam logic [61:0] HALF = 62'd45 << (SH - 1);

      logic [28:0]    mag_ff, mag_in;
      logic [6:0]     sgn_ff;
      div_state_type  div_init_ff, div_init_in;
      div_state_type  div_pipe [DIGITS+1];
      logic [60:0]    prod;
      logic [61:0]    biased;
      logic [61:0]    scaled;
      fix_type        ang_ff, ang_in, qv;
      cordic_vec_type rot_init_ff, rot_init_in;
      logic           neg_in;
      logic [N:0]     neg_ff;
      cordic_vec_type rot_pipe [N+1];

      // stage 1: magnitude and sign
      assign mag_in = raw_ff[l][29] ? 29'(-raw_ff[l]) : raw_ff[l][28:0];

      // stage 2: dividend, degrees times pi over 2^SH, biased so the division by 45 rounds
      always_comb begin
         prod   = mag_ff * PI_MAG;
         biased = {1'b0, prod} + HALF;
         scaled = biased >> SH;
         div_init_in.dividend  = scaled[DW-1:0];
         div_init_in.quotient  = '0;
         div_init_in.remainder = '0;
      end

      assign div_pipe[0] = div_init_ff;

      for (genvar j = 0; j < DIGITS; j++) begin : g_div
         gcd_div_cell u_div (
            .clock     (clock),
            .stage_in  (div_pipe[j]),
            .stage_out (div_pipe[j+1])
         );
      end

      // stage 8: restore sign
      always_comb begin
         qv     = fix_type'(div_pipe[DIGITS].quotient[XW-1:0]);
         ang_in = sgn_ff[6] ? -qv : qv;
      end

      // stage 9: fold into [-pi/2, pi/2]; |angle| < 2*pi here, so no wrap
      always_comb begin
         rot_init_in.x = INV_GAIN;
         rot_init_in.y = '0;
         if (ang_ff > HALF_PI_Q30) begin
            rot_init_in.z = ang_ff - PI_Q30;
            neg_in        = 1'b1;
         end else if (ang_ff < -HALF_PI_Q30) begin
            rot_init_in.z = ang_ff + PI_Q30;
            neg_in        = 1'b1;
         end else begin
            rot_init_in.z = ang_ff;
            neg_in        = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         mag_ff      <= mag_in;
         sgn_ff      <= {sgn_ff[5:0], raw_ff[l][29]};
         div_init_ff <= div_init_in;
         ang_ff      <= ang_in;
         rot_init_ff <= rot_init_in;
         neg_ff      <= {neg_ff[N-1:0], neg_in};
      end

      assign rot_pipe[0] = rot_init_ff;

      for (genvar i = 0; i < N; i++) begin : g_rot
         gcd_cordic_cell #(.IDX(i), .VECTORING(1'b0)) u_rot (
            .clock   (clock),
            .vec_in  (rot_pipe[i]),
            .vec_out (rot_pipe[i+1])
         );
      end

      assign rot_end[l] = rot_pipe[N];
      assign neg_end[l] = neg_ff[N];
   end

   // P0: apply fold sign to sines and cosines
   fix_type sn1_ff, sn2_ff, cs1_ff, cs2_ff;
   fix_type sn1_in, sn2_in, cs1_in, cs2_in;

   always_comb begin
      sn1_in = neg_end[0] ? -rot_end[0].y : rot_end[0].y;
      sn2_in = neg_end[1] ? -rot_end[1].y : rot_end[1].y;
      cs1_in = neg_end[2] ? -rot_end[2].x : rot_end[2].x;
      cs2_in = neg_end[3] ? -rot_end[3].x : rot_end[3].x;
   end

   // P1: three Q30 products
   fix_type sq1_ff, cc_ff, sq2_ff, sq1_in, cc_in, sq2_in;
   logic signed [2*XW-1:0] p_sq1, p_cc, p_sq2, p_sq1_s, p_cc_s, p_sq2_s;

   always_comb begin
      p_sq1   = sn1_ff * sn1_ff;
      p_cc    = cs1_ff * cs2_ff;
      p_sq2   = sn2_ff * sn2_ff;
      p_sq1_s = p_sq1 >>> 30;
      p_cc_s  = p_cc >>> 30;
      p_sq2_s = p_sq2 >>> 30;
      sq1_in  = p_sq1_s[XW-1:0];
      cc_in   = p_cc_s[XW-1:0];
      sq2_in  = p_sq2_s[XW-1:0];
   end

   // P2: cos*cos*sin^2
   fix_type hv1_ff, hv2_ff, hv2_in;
   logic signed [2*XW-1:0] p_hv, p_hv_s;

   always_comb begin
      p_hv   = cc_ff * sq2_ff;
      p_hv_s = p_hv >>> 30;
      hv2_in = p_hv_s[XW-1:0];
   end

   // P3: a, clamped to [0, 1], and the two radicands in Q60
   logic signed [XW:0] a_sum;
   logic [30:0]        a_clip, a_comp;
   sqrt_state_type     sq_init_ff [2];
   sqrt_state_type     sq_init_in [2];

   always_comb begin
      a_sum = {hv1_ff[XW-1], hv1_ff} + {hv2_ff[XW-1], hv2_ff};
      if (a_sum[XW]) begin
         a_clip = '0;
      end else if (a_sum > {ONE_Q30[XW-1], ONE_Q30}) begin
         a_clip = ONE_Q30[30:0];
      end else begin
         a_clip = a_sum[30:0];
      end
      a_comp = ONE_Q30[30:0] - a_clip;
      sq_init_in[0].rad  = {3'd0, a_clip, 30'd0};
      sq_init_in[0].root = '0;
      sq_init_in[1].rad  = {3'd0, a_comp, 30'd0};
      sq_init_in[1].root = '0;
   end

   always_ff @(posedge clock) begin
      sn1_ff     <= sn1_in;
      sn2_ff     <= sn2_in;
      cs1_ff     <= cs1_in;
      cs2_ff     <= cs2_in;
      sq1_ff     <= sq1_in;
      cc_ff      <= cc_in;
      sq2_ff     <= sq2_in;
      hv1_ff     <= sq1_ff;
      hv2_ff     <= hv2_in;
      sq_init_ff <= sq_init_in;
   end

   // square roots: lane 0 is sqrt(a), lane 1 is sqrt(1-a)
   sqrt_state_type sq_pipe [2][SQRT_STEPS+1];

   for (genvar m = 0; m < 2; m++) begin : g_sqrt_lane
      assign sq_pipe[m][0] = sq_init_ff[m];
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
         gcd_sqrt_cell #(.K(k)) u_sqrt (
            .clock  (clock),
            .st_in  (sq_pipe[m][k]),
            .st_out (sq_pipe[m][k+1])
         );
      end
   end

   // atan2 by vectoring
   cordic_vec_type vec_pipe [N+1];

   always_comb begin
      vec_pipe[0].x = fix_type'(sq_pipe[1][SQRT_STEPS].root[XW-1:0]);
      vec_pipe[0].y = fix_type'(sq_pipe[0][SQRT_STEPS].root[XW-1:0]);
      vec_pipe[0].z = '0;
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      gcd_cordic_cell #(.IDX(i), .VECTORING(1'b1)) u_vec (
         .clock   (clock),
         .vec_in  (vec_pipe[i]),
         .vec_out (vec_pipe[i+1])
      );
   end

   // F1: central angle c = 2z, floored at zero
   logic [31:0] cang_ff, cang_in;
   fix_type     zf;

   always_comb begin
      zf      = vec_pipe[N].z;
      cang_in = zf[XW-1] ? 32'd0 : {zf[30:0], 1'b0};
   end

   // F2: radius times angle
   logic [57:0] dprod_ff, dprod_in;
   assign dprod_in = radius_ff * cang_ff;

   // F3: round, saturate, null gating
   logic [58:0] drnd;
   logic [32:0] dscaled;
   logic [31:0] dist_ff, dist_in;

   always_comb begin
      drnd    = {1'b0, dprod_ff} + (59'd1 << 25);
      dscaled = drnd[58:26];
      if (nul_ff[LAT-2]) begin
         dist_in = '0;
      end else if (dscaled[32]) begin
         dist_in = '1;
      end else begin
         dist_in = dscaled[31:0];
      end
   end

   always_ff @(posedge clock) begin
      cang_ff  <= cang_in;
      dprod_ff <= dprod_in;
      dist_ff  <= dist_in;
   end

   assign rsp_strobe      = vld_ff[LAT-1];
   assign rsp_distance    = dist_ff;
   assign rsp_result_null = nul_ff[LAT-1];

endmodule

`default_nettype wire

>>> rtl/core/gcd_checker.sv
// Port-level checker for great_circle_distance_unit, bound to the top level.
// Depends on gcd_pkg for the radius width.
`default_nettype none

module gcd_checker import gcd_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_strobe,
   input logic [31:0]     rsp_distance,
   input logic            rsp_result_null,
   input logic            csr_valid,
   input logic            csr_ready,
   input logic [RADW-1:0] csr_data
);

   localparam int LAT = 49 + 2 * CORDIC_ITERATIONS;

   // every accepted item produces a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted item produced no result");

   // no result without an earlier accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without an accepted item");

   // a null result carries zero distance
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_null) |-> (rsp_distance == 32'd0))
      else $error("null result with nonzero distance");

   // reset drops items in flight: no result strobe right after a reset cycle
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

bind great_circle_distance_unit gcd_checker #(
   .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
) u_gcd_checker (.*);

`default_nettype wire

>>> tb/gcd_distance_checker.sv
// Checker for the great-circle distance unit: watches the request, result and
// radius channels, predicts each distance and compares. Depends on gcd_pkg.
`default_nettype none

module gcd_distance_checker import gcd_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic signed [27:0]  req_start_latitude,
   input  logic signed [28:0]  req_start_longitude,
   input  logic signed [27:0]  req_end_latitude,
   input  logic signed [28:0]  req_end_longitude,
   input  logic                req_start_absent,
   input  logic                req_end_absent,
   input  logic                rsp_strobe,
   input  logic [31:0]         rsp_distance,
   input  logic                rsp_result_null,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [RADW-1:0]     csr_data,
   output int                  error_count,
   output int                  pending
);

   localparam longint PI_VAL     = 64'sd3373259426;
   localparam longint TWO_PI_VAL = 64'sd6746518852;
   localparam longint HALF_PI    = 64'sd1686629713;
   localparam longint ONE_VAL    = 64'sd1073741824;
   localparam longint GAIN_INV   = 64'sd652032874;

   typedef struct {
      logic [31:0] distance;
      logic        is_null;
   } distance_result_type;

   distance_result_type expected_results[$];
   logic [RADW-1:0]     radius;

   // atan(2^-i) in Q30, truncated
   function automatic longint atan_entry(input int i);
      longint head[10];
      head = '{843314856, 497837829, 263043836, 133525158, 67021686,
               33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return head[i];
      if (i <= 30) return (longint'(1) << (30 - i)) - 1;
      return 0;
   endfunction

   // degrees*2^20 to Q30 radians, rounding half away from zero
   function automatic longint to_radians(input longint deg, input longint unsigned div);
      longint unsigned mag, q;
      mag = (deg < 0) ? longint'(-deg) : longint'(deg);
      q = (mag * longint'(PI_VAL) + div / 2) / div;
      return (deg < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic void rotate(input longint ang, output longint s, output longint c);
      longint r, x, y, dx, dy;
      logic   flip;
      r = ang % TWO_PI_VAL;
      flip = 1'b0;
      x = GAIN_INV;
      y = 0;
      if (r > PI_VAL) r -= TWO_PI_VAL;
      else if (r < -PI_VAL) r += TWO_PI_VAL;
      // fold into the right half plane
      if (r > HALF_PI) begin
         r -= PI_VAL;
         flip = 1'b1;
      end else if (r < -HALF_PI) begin
         r += PI_VAL;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (r >= 0) begin
            x -= dx; y += dy; r -= atan_entry(i);
         end else begin
            x += dx; y -= dy; r += atan_entry(i);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic distance_result_type haversine_distance(
      input longint lat1, input longint lon1, input longint lat2, input longint lon2,
      input logic absent1, input logic absent2, input logic [RADW-1:0] rad);
      distance_result_type res;
      longint s1, s2, c1, c2, t, a, x, y, z, dx, dy, ang;
      longint unsigned prod;
      res.distance = '0;
      res.is_null = 1'b1;
      if (absent1 || absent2) return res;
      rotate(to_radians(lat2 - lat1, 64'd360 << 20), s1, t);
      rotate(to_radians(lon2 - lon1, 64'd360 << 20), s2, t);
      rotate(to_radians(lat1, 64'd180 << 20), t, c1);
      rotate(to_radians(lat2, 64'd180 << 20), t, c2);
      a = ((s1 * s1) >>> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
      if (a < 0) a = 0;
      if (a > ONE_VAL) a = ONE_VAL;
      y = longint'(floor_sqrt(longint'(a) << 30));
      x = longint'(floor_sqrt(longint'(ONE_VAL - a) << 30));
      z = 0;
      // vectoring toward y = 0
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_entry(i);
         end else begin
            x -= dx; y += dy; z -= atan_entry(i);
         end
      end
      ang = 2 * z;
      if (ang < 0) ang = 0;
      prod = (longint'(rad) * longint'(ang) + (64'd1 << 25)) >> 26;
      res.distance = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      res.is_null = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending = 0;
      radius = RADIUS_RESET;
   end

   // sample every channel at the clock edge
   always @(posedge clock) begin
      distance_result_type want;
      if (reset) begin
         radius = RADIUS_RESET;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) radius = csr_data;
         if (start && !busy)
            expected_results.push_back(haversine_distance(
               req_start_latitude, req_start_longitude, req_end_latitude,
               req_end_longitude, req_start_absent, req_end_absent, radius));
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_distance, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch("distance", rsp_distance, want.distance);
               if (rsp_result_null !== want.is_null)
                  report_mismatch("result_null", rsp_result_null, want.is_null);
            end
         end
      end
      pending = expected_results.size();
   end

   final begin
      if (expected_results.size() != 0)
         $display("%0d items never returned", expected_results.size());
   end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Top of the great-circle distance testbench: drives items and radius writes
// into great_circle_distance_unit and gives the verdict. Uses gcd_pkg and the checker.
`default_nettype none

module tb import gcd_pkg::*; ();

   localparam int LATENCY = 97;
   localparam int LAT_MAX = 94371840;
   localparam int LON_MAX = 188743680;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [27:0] req_start_latitude = '0;
   logic signed [28:0] req_start_longitude = '0;
   logic signed [27:0] req_end_latitude = '0;
   logic signed [28:0] req_end_longitude = '0;
   logic               req_start_absent = 1'b0;
   logic               req_end_absent = 1'b0;
   logic               rsp_strobe;
   logic [31:0]        rsp_distance;
   logic               rsp_result_null;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RADW-1:0]    csr_data = '0;
   int                 error_count;
   int                 pending;

   always #1 clock = ~clock;

   great_circle_distance_unit uut (.*);

   gcd_distance_checker checker_i (.*);

   // one item; start stays high until a gap lowers it
   task automatic issue(input int lat1, input int lon1, input int lat2, input int lon2,
                        input logic ab1, input logic ab2);
      req_start_latitude  <= lat1[27:0];
      req_start_longitude <= lon1[28:0];
      req_end_latitude    <= lat2[27:0];
      req_end_longitude   <= lon2[28:0];
      req_start_absent    <= ab1;
      req_end_absent      <= ab2;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until idle, then write the radius
   task automatic set_radius(input logic [RADW-1:0] value);
      pause(1);
      wait (pending == 0);
      repeat (LATENCY + 4) @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_lat();
      return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic int rand_lon();
      return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
   endfunction

   // mostly valid coordinates, some raw bit patterns, some absent points
   task automatic random_items(input int count);
      int burst;
      int n;
      int sel;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 30);
         if (burst > count - n) burst = count - n;
         repeat (burst) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
               issue(rand_lat(), rand_lon(), rand_lat(), rand_lon(),
                     $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
            else
               issue($urandom(), $urandom(), $urandom(), $urandom(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            n++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, antipodes, absent flags, wrapped patterns
      issue(0, 0, 0, 0, 1'b0, 1'b0);
      issue(LAT_MAX, 0, -LAT_MAX, 0, 1'b0, 1'b0);
      issue(0, LON_MAX, 0, -LON_MAX, 1'b0, 1'b0);
      issue(0, 0, 0, LON_MAX, 1'b0, 1'b0);
      issue(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1'b0, 1'b0);
      issue(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 1'b0, 1'b0);
      issue(12345678, -23456789, 12345679, -23456789, 1'b0, 1'b0);
      issue(LAT_MAX, 0, LAT_MAX, LON_MAX, 1'b0, 1'b0);
      issue(1000, 2000, 3000, 4000, 1'b1, 1'b0);
      issue(1000, 2000, 3000, 4000, 1'b0, 1'b1);
      issue(1000, 2000, 3000, 4000, 1'b1, 1'b1);
      issue(32'h07FF_FFFF, 32'h0FFF_FFFF, 32'h0800_0000, 32'h1000_0000, 1'b0, 1'b0);
      issue(32'h0800_0000, 32'h1000_0000, 32'h07FF_FFFF, 32'h0FFF_FFFF, 1'b0, 1'b0);
      issue(-1, -1, 1, 1, 1'b0, 1'b0);
      issue(47185920, 0, -47185920, LON_MAX, 1'b0, 1'b0);
      pause(3);
      issue(0, 0, 0, LON_MAX - 1, 1'b0, 1'b0);

      // phases across radius settings, each drained before the write
      random_items(300);
      set_radius(26'h3FF_FFFF);
      issue(LAT_MAX, 0, -LAT_MAX, 0, 1'b0, 1'b0);
      issue(0, 0, 0, LON_MAX, 1'b0, 1'b0);
      random_items(150);
      set_radius(26'd1);
      issue(0, 0, 0, LON_MAX, 1'b0, 1'b0);
      random_items(120);
      set_radius(26'd0);
      issue(0, 0, 0, LON_MAX, 1'b0, 1'b0);
      random_items(60);
      set_radius(RADW'($urandom_range(1, 26'h3FF_FFFF)));
      random_items(120);
      set_radius(RADIUS_RESET);
      random_items(100);
      pause(1);

      wait (pending == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
